// ----- rtl/core/lcd4_pkg.sv -----
// Shared types, codes and the init command table for the 4-bit LCD write sequencer.
// No dependencies; every other file in rtl/core uses it by scoped names.
package lcd4_pkg;

    localparam int unsigned HOLD_W          = 16;
    localparam int unsigned INIT_CMD_COUNT  = 5;
    localparam int unsigned CMD_IDX_W       = 3;
    localparam int unsigned WAKE_STEP_W     = 3;

    localparam logic [3:0] WAKE_NIBBLE      = 4'h3;
    localparam logic [3:0] LAST_WAKE_NIBBLE = 4'h2;
    localparam logic [3:0] CLEAR_NIBBLE     = 4'h0;

    localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] CMD_HOME_ADDR    = 8'h80;
    localparam logic [7:0] CMD_CLEAR        = 8'h01;

    typedef enum logic [1:0] {
        OP_CMD   = 2'd0,
        OP_DATA  = 2'd1,
        OP_RESET = 2'd2,
        OP_INIT  = 2'd3
    } op_t;

    typedef enum logic [7:0] {
        REG_POWER_UP_WAIT   = 8'd0,
        REG_FIRST_WAKE_WAIT = 8'd1,
        REG_SHORT_WAIT      = 8'd2,
        REG_BYTE_WAIT       = 8'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_WAKE,
        ST_BYTE
    } state_t;

    typedef enum logic [1:0] {
        KIND_CLEAR,
        KIND_WAKE,
        KIND_BYTE
    } beat_kind_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] byte_value;
    } in_item_t;

    typedef struct packed {
        logic [3:0]        bus_nibble;
        logic              reg_select;
        logic              enable_pin;
        logic [HOLD_W-1:0] hold_ticks;
        logic              last;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic                   load;
        logic                   emit;
        beat_kind_t             kind;
        logic [WAKE_STEP_W-1:0] wake_step;
        logic [1:0]             phase;
        logic [CMD_IDX_W-1:0]   cmd_idx;
        logic                   last;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic can_emit;
    } dp_status_t;

    function automatic logic [7:0] init_cmd(input logic [CMD_IDX_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = CMD_FUNCTION_SET;
            3'd1:    b = CMD_DISPLAY_ON;
            3'd2:    b = CMD_ENTRY_MODE;
            3'd3:    b = CMD_HOME_ADDR;
            3'd4:    b = CMD_CLEAR;
            default: b = CMD_CLEAR;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/core/lcd4_ctrl.sv -----
// Sequencer state machine: walks clear, wake and byte phases and issues beat commands.
// Depends on lcd4_pkg.
module lcd4_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lcd4_pkg::op_t       in_op,
    input  lcd4_pkg::dp_status_t status,
    output lcd4_pkg::ctrl_cmd_t cmd
);

    lcd4_pkg::state_t state_reg, state_next;
    logic [lcd4_pkg::WAKE_STEP_W-1:0] step_reg, step_next;
    logic [1:0]                       phase_reg, phase_next;
    logic [lcd4_pkg::CMD_IDX_W-1:0]   idx_reg, idx_next;
    logic                             init_last_cmd;

    assign init_last_cmd = (idx_reg == lcd4_pkg::CMD_IDX_W'(lcd4_pkg::INIT_CMD_COUNT - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcd4_pkg::ST_IDLE;
            step_reg  <= '0;
            phase_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
        end
    end

    // next state and counters
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        case (state_reg)
            lcd4_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    step_next  = '0;
                    phase_next = '0;
                    idx_next   = '0;
                    if (in_op inside {lcd4_pkg::OP_CMD, lcd4_pkg::OP_DATA})
                        state_next = lcd4_pkg::ST_BYTE;
                    else
                        state_next = lcd4_pkg::ST_CLEAR;
                end
            end
            lcd4_pkg::ST_CLEAR:
            begin
                if (status.can_emit)
                    state_next = lcd4_pkg::ST_WAKE;
            end
            lcd4_pkg::ST_WAKE:
            begin
                if (status.can_emit)
                begin
                    step_next = step_reg + 1'b1;
                    if (&step_reg)
                    begin
                        if (status.op == lcd4_pkg::OP_INIT)
                            state_next = lcd4_pkg::ST_BYTE;
                        else
                            state_next = lcd4_pkg::ST_IDLE;
                    end
                end
            end
            lcd4_pkg::ST_BYTE:
            begin
                if (status.can_emit)
                begin
                    phase_next = phase_reg + 1'b1;
                    if (&phase_reg)
                    begin
                        if (status.op == lcd4_pkg::OP_INIT && !init_last_cmd)
                            idx_next = idx_reg + 1'b1;
                        else
                            state_next = lcd4_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = lcd4_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.emit      = 1'b0;
        cmd.kind      = lcd4_pkg::KIND_CLEAR;
        cmd.wake_step = step_reg;
        cmd.phase     = phase_reg;
        cmd.cmd_idx   = idx_reg;
        cmd.last      = 1'b0;
        case (state_reg)
            lcd4_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            lcd4_pkg::ST_CLEAR:
            begin
                cmd.emit = status.can_emit;
                cmd.kind = lcd4_pkg::KIND_CLEAR;
            end
            lcd4_pkg::ST_WAKE:
            begin
                cmd.emit = status.can_emit;
                cmd.kind = lcd4_pkg::KIND_WAKE;
                cmd.last = (&step_reg) && (status.op != lcd4_pkg::OP_INIT);
            end
            lcd4_pkg::ST_BYTE:
            begin
                cmd.emit = status.can_emit;
                cmd.kind = lcd4_pkg::KIND_BYTE;
                cmd.last = (&phase_reg) &&
                           (status.op != lcd4_pkg::OP_INIT || init_last_cmd);
            end
            default:
            begin
                cmd.emit = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/core/lcd4_dpath.sv -----
// Datapath: wait registers, latched request, pin-state builder and output register.
// Depends on lcd4_pkg; driven by lcd4_ctrl commands.
module lcd4_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lcd4_pkg::in_item_t            in_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [7:0]                    cfg_index,
    input  logic [lcd4_pkg::HOLD_W-1:0]   cfg_data,
    input  lcd4_pkg::ctrl_cmd_t           cmd,
    output lcd4_pkg::dp_status_t          status,
    output logic                          out_valid,
    input  logic                          out_ready,
    output lcd4_pkg::out_item_t           out_data
);

    logic [lcd4_pkg::HOLD_W-1:0] power_up_wait_reg;
    logic [lcd4_pkg::HOLD_W-1:0] first_wake_wait_reg;
    logic [lcd4_pkg::HOLD_W-1:0] short_wait_reg;
    logic [lcd4_pkg::HOLD_W-1:0] byte_wait_reg;

    lcd4_pkg::op_t       op_reg;
    logic [7:0]          byte_reg;
    lcd4_pkg::out_item_t beat_reg, beat_next;
    logic                out_valid_reg;
    logic [7:0]          cur_byte;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_up_wait_reg   <= 16'd20000;
            first_wake_wait_reg <= 16'd10000;
            short_wait_reg      <= 16'd1000;
            byte_wait_reg       <= 16'd4000;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lcd4_pkg::REG_POWER_UP_WAIT:   power_up_wait_reg   <= cfg_data;
                lcd4_pkg::REG_FIRST_WAKE_WAIT: first_wake_wait_reg <= cfg_data;
                lcd4_pkg::REG_SHORT_WAIT:      short_wait_reg      <= cfg_data;
                lcd4_pkg::REG_BYTE_WAIT:       byte_wait_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            op_reg <= lcd4_pkg::OP_CMD;
        else if (cmd.load)
            op_reg <= in_data.op;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            byte_reg <= in_data.byte_value;
    end

    assign cur_byte = (op_reg == lcd4_pkg::OP_INIT) ? lcd4_pkg::init_cmd(cmd.cmd_idx)
                                                    : byte_reg;

    always_comb
    begin
        beat_next            = '0;
        beat_next.last       = cmd.last;
        case (cmd.kind)
            lcd4_pkg::KIND_CLEAR:
            begin
                beat_next.bus_nibble = lcd4_pkg::CLEAR_NIBBLE;
                beat_next.hold_ticks = power_up_wait_reg;
            end
            lcd4_pkg::KIND_WAKE:
            begin
                // the fourth strobe switches to 4-bit mode
                beat_next.bus_nibble = (&cmd.wake_step[2:1]) ? lcd4_pkg::LAST_WAKE_NIBBLE
                                                             : lcd4_pkg::WAKE_NIBBLE;
                beat_next.enable_pin = !cmd.wake_step[0];
                if (cmd.wake_step[0])
                    beat_next.hold_ticks = (cmd.wake_step[2:1] == 2'd0) ? first_wake_wait_reg
                                                                        : short_wait_reg;
            end
            lcd4_pkg::KIND_BYTE:
            begin
                beat_next.bus_nibble = cmd.phase[1] ? cur_byte[3:0] : cur_byte[7:4];
                beat_next.reg_select = (op_reg == lcd4_pkg::OP_DATA);
                beat_next.enable_pin = !cmd.phase[0];
                if (&cmd.phase)
                    beat_next.hold_ticks = byte_wait_reg;
            end
            default: ;
        endcase
    end

    // output register: hold until taken, refill on the same edge when drained
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            beat_reg <= beat_next;
    end

    assign status.op       = op_reg;
    assign status.can_emit = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = beat_reg;

endmodule

// ----- rtl/core/char_lcd_nibble_write_sequencer_unit.sv -----
// Top level of the 4-bit character LCD write sequencer.
// Depends on lcd4_pkg, lcd4_ctrl and lcd4_dpath.
//
//  channel | signals                          | beat
//  --------+----------------------------------+-------------------------------------
//  in      | in_valid in_ready in_data        | one operation (op, byte_value)
//  out     | out_valid out_ready out_data     | one pin state with its hold time
//  cfg     | cfg_valid cfg_ready cfg_index    | one 16-bit wait register write
//          | cfg_data                         |
//
// One pin state leaves per cycle while out_ready stays high: 4 beats for command
// or data, 9 for reset, 29 for init, plus a pass through idle to take the request.
// A new request is taken once the sequencer walks back to idle, even while the
// final beat still sits in the output register. Stalls on out_ready freeze the
// sequence. Reset restores the default waits and empties the output register.
module char_lcd_nibble_write_sequencer_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  lcd4_pkg::in_item_t          in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output lcd4_pkg::out_item_t         out_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [7:0]                  cfg_index,
    input  logic [lcd4_pkg::HOLD_W-1:0] cfg_data
);

    lcd4_pkg::ctrl_cmd_t  cmd;
    lcd4_pkg::dp_status_t status;

    lcd4_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_op    (in_data.op),
        .status   (status),
        .cmd      (cmd)
    );

    lcd4_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ----- sim/char_lcd_nibble_write_sequencer_unit_test.sv -----
// Self-checking testbench for char_lcd_nibble_write_sequencer_unit: a directed table and then
// random operations, with every pin state checked against a behavioral predictor.
// Depends on lcd4_pkg and the RTL under rtl/core.
module char_lcd_nibble_write_sequencer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lcd4_pkg::*;

    localparam logic [15:0] POWER_UP_DEFAULT   = 16'd20000;
    localparam logic [15:0] FIRST_WAKE_DEFAULT = 16'd10000;
    localparam logic [15:0] SHORT_DEFAULT      = 16'd1000;
    localparam logic [15:0] BYTE_DEFAULT       = 16'd4000;

    localparam int RANDOM_OPS      = 300;
    localparam int CFG_EVERY       = 60;
    localparam int PAUSE_AT        = 150;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 40;
    localparam int HOLD_OFF_AT     = 600;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 2000;

    typedef struct {
        bit          is_cfg;
        logic [7:0]  idx;
        logic [15:0] val;
        in_item_t    item;
        bit          typed;
        out_item_t   first;
    } step_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [15:0] cfg_data;

    // predictor's copy of the wait registers
    logic [15:0] wait_power;
    logic [15:0] wait_first;
    logic [15:0] wait_short;
    logic [15:0] wait_byte;

    out_item_t pin_q[$];
    out_item_t want;
    step_row_t dir_rows[$];
    int        errors;
    int        send_calm;
    int        sink_calm;
    int        idle_cycles;

    char_lcd_nibble_write_sequencer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic out_item_t pin(input logic [3:0] nib, input logic rs, input logic en,
                                      input logic [15:0] hold, input logic fin);
        out_item_t p;
        p.bus_nibble = nib;
        p.reg_select = rs;
        p.enable_pin = en;
        p.hold_ticks = hold;
        p.last       = fin;
        return p;
    endfunction

    function automatic void push_strobe(input logic [3:0] nib, input logic rs,
                                        input logic [15:0] hold);
        pin_q.push_back(pin(nib, rs, 1'b1, 16'd0, 1'b0));
        pin_q.push_back(pin(nib, rs, 1'b0, hold, 1'b0));
    endfunction

    function automatic void push_byte(input logic [7:0] b, input logic rs);
        push_strobe(b[7:4], rs, 16'd0);
        push_strobe(b[3:0], rs, wait_byte);
    endfunction

    function automatic void push_wake();
        pin_q.push_back(pin(CLEAR_NIBBLE, 1'b0, 1'b0, wait_power, 1'b0));
        push_strobe(WAKE_NIBBLE, 1'b0, wait_first);
        push_strobe(WAKE_NIBBLE, 1'b0, wait_short);
        push_strobe(WAKE_NIBBLE, 1'b0, wait_short);
        push_strobe(LAST_WAKE_NIBBLE, 1'b0, wait_short);
    endfunction

    // Queue every pin state one operation produces; flag the final one.
    function automatic void plan_pins(input in_item_t it);
        logic [7:0] setup [5];
        setup[0] = CMD_FUNCTION_SET;
        setup[1] = CMD_DISPLAY_ON;
        setup[2] = CMD_ENTRY_MODE;
        setup[3] = CMD_HOME_ADDR;
        setup[4] = CMD_CLEAR;
        case (it.op)
            OP_CMD:   push_byte(it.byte_value, 1'b0);
            OP_DATA:  push_byte(it.byte_value, 1'b1);
            OP_RESET: push_wake();
            default:
            begin
                push_wake();
                for (int i = 0; i < 5; i++)
                    push_byte(setup[i], 1'b0);
            end
        endcase
        pin_q[pin_q.size() - 1].last = 1'b1;
    endfunction

    function automatic void set_wait(input logic [7:0] idx, input logic [15:0] val);
        case (idx)
            REG_POWER_UP_WAIT:   wait_power = val;
            REG_FIRST_WAKE_WAIT: wait_first = val;
            REG_SHORT_WAIT:      wait_short = val;
            REG_BYTE_WAIT:       wait_byte  = val;
            default:             ;
        endcase
    endfunction

    // Gap before the next beat; a calm stretch gives several beats with no gap.
    function automatic int draw_gap(ref int calm_left);
        if (calm_left == 0 && $urandom_range(0, 3) == 0)
            calm_left = $urandom_range(5, 25);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    function automatic step_row_t op_row(input op_t op, input logic [7:0] b);
        step_row_t r;
        r.is_cfg          = 1'b0;
        r.idx             = 8'd0;
        r.val             = 16'd0;
        r.item.op         = op;
        r.item.byte_value = b;
        r.typed           = 1'b0;
        r.first           = '0;
        return r;
    endfunction

    function automatic step_row_t typed_row(input op_t op, input logic [7:0] b,
                                            input out_item_t first);
        step_row_t r;
        r       = op_row(op, b);
        r.typed = 1'b1;
        r.first = first;
        return r;
    endfunction

    function automatic step_row_t cfg_row(input logic [7:0] idx, input logic [15:0] val);
        step_row_t r;
        r        = op_row(OP_CMD, 8'd0);
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        return r;
    endfunction

    // Offer one operation; queue its pin states once the beat is taken.
    task automatic offer(input in_item_t it, input bit typed, input out_item_t first);
        int gap;
        int base;
        gap = draw_gap(send_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data  <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        base = pin_q.size();
        plan_pins(it);
        // hand-typed first pin state replaces the predicted one
        if (typed)
            pin_q[base] = first;
    endtask

    task automatic settle();
        while (pin_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [7:0] idx, input logic [15:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        set_wait(idx, val);
    endtask

    // Compare each accepted pin state with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pin_q.size() == 0)
            begin
                $error("pin state with nothing expected: %h", out_data);
                errors++;
            end
            else
            begin
                want = pin_q.pop_front();
                if (out_data.bus_nibble !== want.bus_nibble)
                begin
                    $error("bus_nibble: expected %h, got %h", want.bus_nibble, out_data.bus_nibble);
                    errors++;
                end
                if (out_data.reg_select !== want.reg_select)
                begin
                    $error("reg_select: expected %b, got %b", want.reg_select, out_data.reg_select);
                    errors++;
                end
                if (out_data.enable_pin !== want.enable_pin)
                begin
                    $error("enable_pin: expected %b, got %b", want.enable_pin, out_data.enable_pin);
                    errors++;
                end
                if (out_data.hold_ticks !== want.hold_ticks)
                begin
                    $error("hold_ticks: expected %0d, got %0d", want.hold_ticks,
                           out_data.hold_ticks);
                    errors++;
                end
                if (out_data.last !== want.last)
                begin
                    $error("last: expected %b, got %b", want.last, out_data.last);
                    errors++;
                end
            end
        end
    end

    // Output side: random gaps, plus one long hold-off to back up the input.
    initial
    begin : sink
        int gap;
        int beats_seen;
        bit held_off;
        beats_seen = 0;
        held_off   = 1'b0;
        out_ready  = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = draw_gap(sink_calm);
            // hold off only while the sender is offering, so the input backs up
            if (!held_off && beats_seen >= HOLD_OFF_AT && in_valid)
            begin
                gap      = HOLD_OFF_CYCLES;
                held_off = 1'b1;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            beats_seen++;
        end
    end

    initial
    begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        bit       prev_cfg;
        in_item_t it;
        int       pick;
        int       n_writes;
        logic [7:0]  idx;
        logic [15:0] val;

        clk        = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = 8'd0;
        cfg_data   = 16'd0;
        errors     = 0;
        send_calm  = 0;
        sink_calm  = 0;
        wait_power = POWER_UP_DEFAULT;
        wait_first = FIRST_WAKE_DEFAULT;
        wait_short = SHORT_DEFAULT;
        wait_byte  = BYTE_DEFAULT;

        // defaults after reset; first pin states typed in
        dir_rows.push_back(typed_row(OP_CMD, 8'hFF, pin(4'hF, 1'b0, 1'b1, 16'd0, 1'b0)));
        dir_rows.push_back(typed_row(OP_DATA, 8'h00, pin(4'h0, 1'b1, 1'b1, 16'd0, 1'b0)));
        dir_rows.push_back(typed_row(OP_RESET, 8'h00,
                                     pin(CLEAR_NIBBLE, 1'b0, 1'b0, POWER_UP_DEFAULT, 1'b0)));
        dir_rows.push_back(typed_row(OP_INIT, 8'hFF,
                                     pin(CLEAR_NIBBLE, 1'b0, 1'b0, POWER_UP_DEFAULT, 1'b0)));
        dir_rows.push_back(op_row(OP_DATA, 8'hFF));
        dir_rows.push_back(op_row(OP_CMD, 8'h00));
        // all waits zero
        dir_rows.push_back(cfg_row(REG_POWER_UP_WAIT, 16'h0000));
        dir_rows.push_back(cfg_row(REG_FIRST_WAKE_WAIT, 16'h0000));
        dir_rows.push_back(cfg_row(REG_SHORT_WAIT, 16'h0000));
        dir_rows.push_back(cfg_row(REG_BYTE_WAIT, 16'h0000));
        dir_rows.push_back(typed_row(OP_RESET, 8'h5A,
                                     pin(CLEAR_NIBBLE, 1'b0, 1'b0, 16'd0, 1'b0)));
        dir_rows.push_back(op_row(OP_INIT, 8'h00));
        dir_rows.push_back(op_row(OP_CMD, 8'hA5));
        dir_rows.push_back(op_row(OP_DATA, 8'h5A));
        // all waits at maximum; out-of-range indexes must be dropped
        dir_rows.push_back(cfg_row(REG_POWER_UP_WAIT, 16'hFFFF));
        dir_rows.push_back(cfg_row(REG_FIRST_WAKE_WAIT, 16'hFFFF));
        dir_rows.push_back(cfg_row(REG_SHORT_WAIT, 16'hFFFF));
        dir_rows.push_back(cfg_row(REG_BYTE_WAIT, 16'hFFFF));
        dir_rows.push_back(cfg_row(8'd4, 16'h1234));
        dir_rows.push_back(cfg_row(8'hFF, 16'h0000));
        dir_rows.push_back(typed_row(OP_INIT, 8'hA5,
                                     pin(CLEAR_NIBBLE, 1'b0, 1'b0, 16'hFFFF, 1'b0)));
        dir_rows.push_back(typed_row(OP_DATA, 8'h3C, pin(4'h3, 1'b1, 1'b1, 16'd0, 1'b0)));
        dir_rows.push_back(op_row(OP_CMD, 8'hC3));
        dir_rows.push_back(op_row(OP_RESET, 8'hFF));
        // distinct small waits so a swapped register shows up
        dir_rows.push_back(cfg_row(REG_POWER_UP_WAIT, 16'd1));
        dir_rows.push_back(cfg_row(REG_FIRST_WAKE_WAIT, 16'd2));
        dir_rows.push_back(cfg_row(REG_SHORT_WAIT, 16'd3));
        dir_rows.push_back(cfg_row(REG_BYTE_WAIT, 16'd4));
        dir_rows.push_back(op_row(OP_INIT, 8'h00));
        dir_rows.push_back(op_row(OP_CMD, 8'h0F));
        dir_rows.push_back(op_row(OP_DATA, 8'hF0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        prev_cfg = 1'b0;
        foreach (dir_rows[k])
        begin
            if (dir_rows[k].is_cfg)
            begin
                if (!prev_cfg)
                begin
                    in_valid <= 1'b0;
                    settle();
                end
                cfg_write(dir_rows[k].idx, dir_rows[k].val);
            end
            else
            begin
                if (prev_cfg)
                    cfg_valid <= 1'b0;
                offer(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].first);
            end
            prev_cfg = dir_rows[k].is_cfg;
        end

        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            if (i % CFG_EVERY == CFG_EVERY - 1)
            begin
                in_valid <= 1'b0;
                settle();
                n_writes = $urandom_range(1, 4);
                for (int w = 0; w < n_writes; w++)
                begin
                    if ($urandom_range(0, 4) == 0)
                        idx = 8'($urandom_range(0, 255));
                    else
                        idx = 8'($urandom_range(0, 3));
                    case ($urandom_range(0, 3))
                        0:       val = 16'h0000;
                        1:       val = 16'hFFFF;
                        default: val = 16'($urandom_range(0, 65535));
                    endcase
                    cfg_write(idx, val);
                end
                cfg_valid <= 1'b0;
            end
            else if (i == PAUSE_AT)
            begin
                // hold off until every queued pin state has drained
                in_valid <= 1'b0;
                while (pin_q.size() != 0)
                    @(posedge clk);
            end
            pick = $urandom_range(0, 9);
            if (pick < 4)
                it.op = OP_CMD;
            else if (pick < 8)
                it.op = OP_DATA;
            else if (pick == 8)
                it.op = OP_RESET;
            else
                it.op = OP_INIT;
            it.byte_value = 8'($urandom_range(0, 255));
            offer(it, 1'b0, '0);
        end

        in_valid <= 1'b0;
        while (pin_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pin_q.size() != 0)
        begin
            $error("%0d pin states never arrived", pin_q.size());
            errors++;
        end
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- char_lcd_nibble_write_sequencer_unit.f -----
rtl/core/lcd4_pkg.sv
rtl/core/lcd4_ctrl.sv
rtl/core/lcd4_dpath.sv
rtl/core/char_lcd_nibble_write_sequencer_unit.sv
sim/char_lcd_nibble_write_sequencer_unit_test.sv
